// ===== hw/rtl/hav_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_pkg
// Shared constants and helpers for the haversine distance pipeline.
// ----------------------------------------------------------------------------
package hav_pkg;

	localparam int CordicStepsDefault = 24;
	localparam int RadiusW = 24;
	localparam int DistW = 34;
	localparam logic [RadiusW-1:0] RadiusReset = 24'd6371000;

	// Q30 values carried in 36-bit signed words
	localparam int QW = 36;
	localparam logic signed [QW-1:0] OneQ = 36'sd1073741824;
	localparam logic signed [QW-1:0] HalfPiQ = 36'sd1686629713;
	localparam logic signed [QW-1:0] PiQ = 36'sd3373259426;
	localparam logic signed [QW-1:0] GainInvQ = 36'sd652032874;
	localparam logic [29:0] Deg7ToRad = 30'd1006113814;

	// CORDIC step angle, Q30
	function automatic logic signed [QW-1:0] step_angle(input int i);
		logic signed [QW-1:0] r;
		r = '0;
		case (i)
			0: r = 36'sd843314856;
			1: r = 36'sd497837829;
			2: r = 36'sd263043836;
			3: r = 36'sd133525158;
			4: r = 36'sd67021686;
			5: r = 36'sd33543515;
			6: r = 36'sd16775850;
			7: r = 36'sd8388437;
			8: r = 36'sd4194282;
			9: r = 36'sd2097149;
			default: begin
				if (i <= 30) r = 36'sd1 <<< (30 - i);
			end
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/haversine_distance.sv =====
`timescale 1ns / 1ps
// Throughput: one pair per cycle; busy is held low, start is taken every cycle.
// The depth is set by the two CORDIC pipelines and the 32-stage root pipeline.
// done is never stalled: each result shows for a single cycle.
// Reset clears the valid pipe and loads the radius register with 6371000;
// datapath registers are not reset.
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between two points given in 1e-7 degree units.
// ----------------------------------------------------------------------------
module haversine_distance #(
	parameter int CORDIC_STEPS = hav_pkg::CordicStepsDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [30:0]            first_latitude,
	input  logic signed [31:0]            first_longitude,
	input  logic signed [30:0]            second_latitude,
	input  logic signed [31:0]            second_longitude,
	output logic                          done,
	output logic [hav_pkg::DistW-1:0]     distance,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hav_pkg::RadiusW-1:0]   cfg_data
);
	localparam int W = hav_pkg::QW;
	// stages: s1 prep, product, s2 radians, rot (STEPS+1), p1..p4 products,
	// sqrt (32), vec (STEPS+1), m1 scale, output register
	localparam int Lat = 2 * CORDIC_STEPS + 43;

	logic [hav_pkg::RadiusW-1:0] radius_q;
	logic [Lat-1:0] vld_q;
	logic en;

	assign en = 1'b1;     // receiver never stalls
	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= hav_pkg::RadiusReset;
			vld_q <= '0;
		end else begin
			if (cfg_valid) radius_q <= cfg_data;
			vld_q <= {vld_q[Lat-2:0], start};
		end
	end

	// ---- stage 1: differences, magnitudes, products with pi/1.8e9 ----
	logic [32:0] mag_s1 [4];
	logic        neg_s1 [4];
	logic [62:0] prod_s1 [4];
	logic [32:0] d_in [4];

	always_comb begin
		d_in[0] = 33'(33'(signed'(second_latitude)) - 33'(signed'(first_latitude)));
		d_in[1] = 33'(33'(signed'(second_longitude)) - 33'(signed'(first_longitude)));
		d_in[2] = 33'(signed'(first_latitude));
		d_in[3] = 33'(signed'(second_latitude));
	end

	for (genvar k = 0; k < 4; k++) begin : g_rad
		always_ff @(posedge clk) begin
			neg_s1[k] <= d_in[k][32];
			mag_s1[k] <= d_in[k][32] ? 33'(-d_in[k]) : d_in[k];
		end
		logic [62:0] rnd;
		logic [62:0] shr;
		assign rnd = (k < 2) ? 63'(1) << 29 : 63'(1) << 28;
		assign shr = (prod_s1[k] + rnd) >> ((k < 2) ? 30 : 29);
		logic signed [W-1:0] th_s2;
		always_ff @(posedge clk) begin
			prod_s1[k] <= 63'(mag_s1[k]) * 63'(hav_pkg::Deg7ToRad);
		end
		// neg registered again in neg_d to line up with prod
		logic neg_d;
		always_ff @(posedge clk) begin
			neg_d <= neg_s1[k];
			th_s2 <= neg_d ? -W'(shr) : W'(shr);
		end
		logic signed [W-1:0] s_o, c_o;
		hav_rot #(.STEPS(CORDIC_STEPS)) u_rot (
			.clk(clk), .en(en), .theta(th_s2),
			.sin_o(s_o), .cos_o(c_o));
		logic signed [W-1:0] s_r, c_r;
		assign s_r = s_o;
		assign c_r = c_o;
	end

	// ---- products: p1 squares and cos product, p2 rounding, p3 term ----
	logic signed [71:0] sl2_p1, sn2_p1, cp_p1;
	logic signed [W-1:0] sl2_p2, sn2_p2, cp_p2;
	logic signed [71:0] term_p3;
	logic signed [W-1:0] sl2_p3;
	logic signed [W-1:0] a_p4;

	always_ff @(posedge clk) begin
		sl2_p1 <= 72'(g_rad[0].s_r) * 72'(g_rad[0].s_r);
		sn2_p1 <= 72'(g_rad[1].s_r) * 72'(g_rad[1].s_r);
		cp_p1  <= 72'(g_rad[2].c_r) * 72'(g_rad[3].c_r);
		sl2_p2 <= W'((sl2_p1 + 72'sd536870912) >>> 30);
		sn2_p2 <= W'((sn2_p1 + 72'sd536870912) >>> 30);
		cp_p2  <= W'((cp_p1 + 72'sd536870912) >>> 30);
		term_p3 <= 72'(sn2_p2) * 72'(cp_p2);
		sl2_p3 <= sl2_p2;
	end

	logic signed [W+1:0] a_sum;
	assign a_sum = (W+2)'(sl2_p3) + (W+2)'((term_p3 + 72'sd536870912) >>> 30);

	always_ff @(posedge clk) begin
		if (a_sum < 0) a_p4 <= '0;
		else if (a_sum > (W+2)'(hav_pkg::OneQ)) a_p4 <= hav_pkg::OneQ;
		else a_p4 <= W'(a_sum);
	end

	// ---- square roots of a and 1-a ----
	logic [30:0] ry, rx;
	logic [30:0] one_m_a;
	assign one_m_a = 31'(hav_pkg::OneQ - a_p4);

	hav_sqrt u_sqy (.clk(clk), .en(en), .val(a_p4[30:0]), .root(ry));
	hav_sqrt u_sqx (.clk(clk), .en(en), .val(one_m_a), .root(rx));

	// zero flag rides alongside the root and vectoring pipes
	localparam int ZD = 32 + CORDIC_STEPS + 1;
	logic [ZD-1:0] zero_q;
	always_ff @(posedge clk) zero_q <= {zero_q[ZD-2:0], (a_p4 == '0)};

	logic signed [W-1:0] z_v;
	hav_vec #(.STEPS(CORDIC_STEPS)) u_vec (
		.clk(clk), .en(en), .x_in(W'(rx)), .y_in(W'(ry)), .z_out(z_v));

	// ---- scale by radius, round, saturate ----
	logic [60:0] m_m1;
	logic        zero_m1;
	logic [38:0] d_w;
	always_ff @(posedge clk) begin
		m_m1 <= 61'(radius_q) * 61'((z_v < 0) ? '0 : {z_v[W-2:0], 1'b0});
		zero_m1 <= zero_q[ZD-1];
	end
	assign d_w = 39'((m_m1 + 61'd2097152) >> 22);
	always_ff @(posedge clk) begin
		if (zero_m1) distance <= '0;
		else if (d_w > 39'h3FFFFFFFF) distance <= '1;
		else distance <= d_w[33:0];
	end

	assign done = vld_q[Lat-1];
endmodule

// ===== hw/rtl/hav_rot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_rot
// Pipelined rotation-mode CORDIC: sine and cosine of a Q30 angle.
// One micro-rotation per stage, with range reflection at the input.
// ----------------------------------------------------------------------------
module hav_rot #(
	parameter int STEPS = hav_pkg::CordicStepsDefault
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [hav_pkg::QW-1:0] theta,
	output logic signed [hav_pkg::QW-1:0] sin_o,
	output logic signed [hav_pkg::QW-1:0] cos_o
);
	localparam int W = hav_pkg::QW;

	logic signed [W-1:0] x_s [STEPS+1];
	logic signed [W-1:0] y_s [STEPS+1];
	logic signed [W-1:0] z_s [STEPS+1];
	logic                f_s [STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= hav_pkg::GainInvQ;
			y_s[0] <= '0;
			if (theta > hav_pkg::HalfPiQ) begin
				z_s[0] <= hav_pkg::PiQ - theta;
				f_s[0] <= 1'b1;
			end else if (theta < -hav_pkg::HalfPiQ) begin
				z_s[0] <= -hav_pkg::PiQ - theta;
				f_s[0] <= 1'b1;
			end else begin
				z_s[0] <= theta;
				f_s[0] <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				f_s[i+1] <= f_s[i];
				if (!z_s[i][W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - hav_pkg::step_angle(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + hav_pkg::step_angle(i);
				end
			end
		end
	end

	assign sin_o = y_s[STEPS];
	assign cos_o = f_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
endmodule

// ===== hw/rtl/hav_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_sqrt
// Pipelined floor square root of a 31-bit Q30 value shifted left by 30.
// One result bit per stage, restoring method.
// ----------------------------------------------------------------------------
module hav_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] val,
	output logic [30:0] root
);
	localparam int N = 31;

	logic [61:0] rem_s  [N+1];
	logic [30:0] r_s    [N+1];
	logic [61:0] arg_s  [N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			arg_s[0] <= {val, 31'd0} >> 1;
			rem_s[0] <= '0;
			r_s[0]   <= '0;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_bit
		logic [63:0] trial;
		logic [63:0] cur;
		assign cur   = {rem_s[k], arg_s[k][61:60]};
		assign trial = {31'd0, r_s[k], 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				arg_s[k+1] <= {arg_s[k][59:0], 2'b00};
				if (cur >= trial) begin
					rem_s[k+1] <= 62'(cur - trial);
					r_s[k+1]   <= {r_s[k][29:0], 1'b1};
				end else begin
					rem_s[k+1] <= cur[61:0];
					r_s[k+1]   <= {r_s[k][29:0], 1'b0};
				end
			end
		end
	end

	assign root = r_s[N];
endmodule

// ===== hw/rtl/hav_vec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hav_vec
// Pipelined vectoring-mode CORDIC: angle of (x, y), Q30.
// ----------------------------------------------------------------------------
module hav_vec #(
	parameter int STEPS = hav_pkg::CordicStepsDefault
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [hav_pkg::QW-1:0] x_in,
	input  logic signed [hav_pkg::QW-1:0] y_in,
	output logic signed [hav_pkg::QW-1:0] z_out
);
	localparam int W = hav_pkg::QW;

	logic signed [W-1:0] x_s [STEPS+1];
	logic signed [W-1:0] y_s [STEPS+1];
	logic signed [W-1:0] z_s [STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= x_in;
			y_s[0] <= y_in;
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][W-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + hav_pkg::step_angle(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - hav_pkg::step_angle(i);
				end
			end
		end
	end

	assign z_out = z_s[STEPS];
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for haversine_distance. A directed table and then random
// coordinate pairs are driven with random gaps. Every distance beat is compared
// with a bit-exact fixed-point predictor or a typed-in value, at several radii.
// ----------------------------------------------------------------------------
module testbench;

	localparam int Steps = hav_pkg::CordicStepsDefault;
	localparam int DistW = hav_pkg::DistW;
	localparam int RadiusW = hav_pkg::RadiusW;
	localparam logic [RadiusW-1:0] RadiusReset = hav_pkg::RadiusReset;
	localparam int DrainCycles = 2 * Steps + 60;	// latency plus margin
	localparam int CycleLimit = 400000;
	localparam longint unsigned DegToRad = 64'd1006113814;
	localparam longint OneQl = 64'sd1073741824;
	localparam longint HalfPiQl = 64'sd1686629713;
	localparam longint PiQl = 64'sd3373259426;
	localparam longint GainInvQl = 64'sd652032874;
	localparam longint unsigned DistMax = 64'd17179869183;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [30:0] first_latitude = '0;
	logic signed [31:0] first_longitude = '0;
	logic signed [30:0] second_latitude = '0;
	logic signed [31:0] second_longitude = '0;
	logic done;
	logic [DistW-1:0] distance;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [RadiusW-1:0] cfg_data = '0;

	// Radius as the predictor sees it; follows every accepted config beat
	logic [RadiusW-1:0] radius_model;

	// Expected distances in issue order, predicted or typed-in
	logic [DistW-1:0] dist_expected[$];
	int errors = 0;
	int cycles = 0;

	haversine_distance #(.CORDIC_STEPS(Steps)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.first_latitude(first_latitude),
		.first_longitude(first_longitude),
		.second_latitude(second_latitude),
		.second_longitude(second_longitude),
		.done(done),
		.distance(distance),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor
	function automatic longint rot_angle(input int i);
		longint tab[10];
		tab = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149};
		if (i < 10) return tab[i];
		if (i <= 30) return longint'(1) << (30 - i);
		return 0;
	endfunction

	// Arithmetic (floor) shift, capped at 62
	function automatic longint floor_shift(input longint v, input int s);
		if (s > 62) s = 62;
		return v >>> s;
	endfunction

	// 1e-7 degree to radians in Q(59-sh); rounds the magnitude, sign applied after
	function automatic longint deg_to_q30(input longint d, input int sh);
		longint unsigned m, r;
		m = (d < 0) ? longint'(-d) : d;
		r = (m * DegToRad + (64'd1 << (sh - 1))) >> sh;
		return (d < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic void rotate_sincos(input longint th, output longint s,
		output longint c);
		longint x, y, dx, dy;
		bit flip;
		x = GainInvQl;
		y = 0;
		flip = 0;
		// fold into +-pi/2, cosine changes sign
		if (th > HalfPiQl) begin
			th = PiQl - th;
			flip = 1;
		end else if (th < -HalfPiQl) begin
			th = -PiQl - th;
			flip = 1;
		end
		for (int i = 0; i < Steps; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (th >= 0) begin
				x -= dx; y += dy; th -= rot_angle(i);
			end else begin
				x += dx; y -= dy; th += rot_angle(i);
			end
		end
		s = y;
		c = flip ? -x : x;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [DistW-1:0] great_circle(input longint lat1,
		input longint lon1, input longint lat2, input longint lon2,
		input logic [RadiusW-1:0] rad);
		longint sl, cl, sn, cn, s1, c1, s2, c2, cp, term, a, x, y, z, dx, dy;
		longint unsigned sl2, sn2, span;
		rotate_sincos(deg_to_q30(lat2 - lat1, 30), sl, cl);
		rotate_sincos(deg_to_q30(lon2 - lon1, 30), sn, cn);
		rotate_sincos(deg_to_q30(lat1, 29), s1, c1);
		rotate_sincos(deg_to_q30(lat2, 29), s2, c2);
		sl2 = (longint'(sl * sl) + (64'd1 << 29)) >> 30;
		sn2 = (longint'(sn * sn) + (64'd1 << 29)) >> 30;
		cp = floor_shift(c1 * c2 + (longint'(1) << 29), 30);
		term = floor_shift(longint'(sn2) * cp + (longint'(1) << 29), 30);
		a = longint'(sl2) + term;
		if (a < 0) a = 0;
		if (a > OneQl) a = OneQl;
		if (a == 0) return '0;	// coincident points: exact zero
		y = longint'(floor_sqrt(longint'(a) << 30));
		x = longint'(floor_sqrt(longint'(OneQl - a) << 30));
		z = 0;
		for (int i = 0; i < Steps; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += rot_angle(i);
			end else begin
				x -= dx; y += dy; z -= rot_angle(i);
			end
		end
		if (z < 0) z = 0;
		span = (longint'(rad) * longint'(2 * z) + (64'd1 << 21)) >> 22;
		if (span > DistMax) span = DistMax;
		return span[DistW-1:0];
	endfunction

	// ------------------------------------------------------------------ monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (dist_expected.size() == 0) begin
				$display("%0t: unexpected distance beat, actual %0d", $time, distance);
				errors++;
			end else begin
				if (distance !== dist_expected[0]) begin
					$display("%0t: distance mismatch, expected %0d actual %0d",
						$time, dist_expected[0], distance);
					errors++;
				end
				void'(dist_expected.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ------------------------------------------------------------------ drivers
	// One command beat; typed-in expectation overrides the predictor when set.
	// start stays high after the beat so back-to-back beats need no second drive.
	task automatic send_pair(input logic signed [30:0] la1, input logic signed [31:0] lo1,
		input logic signed [30:0] la2, input logic signed [31:0] lo2,
		input bit typed, input logic [DistW-1:0] typed_dist, input int gap);
		logic [DistW-1:0] pred;
		if (gap > 0) start <= 1'b0;
		repeat (gap) @(posedge clk);
		start <= 1'b1;
		first_latitude <= la1;
		first_longitude <= lo1;
		second_latitude <= la2;
		second_longitude <= lo2;
		do @(posedge clk); while (busy);
		pred = great_circle(la1, lo1, la2, lo2, radius_model);
		if (typed && pred !== typed_dist)
			$display("%0t: note, predictor gives %0d for a typed row", $time, pred);
		dist_expected.insert(dist_expected.size(), typed ? typed_dist : pred);
	endtask

	// Waits until nothing is in flight before writing
	task automatic write_radius(input logic [RadiusW-1:0] r);
		start <= 1'b0;
		wait (dist_expected.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= r;
		do @(posedge clk); while (!cfg_ready);
		radius_model = r;
		cfg_valid <= 1'b0;
	endtask

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 6);
	endfunction

	task automatic random_pairs(input int n);
		logic signed [30:0] la1, la2;
		logic signed [31:0] lo1, lo2;
		int kind;
		bit burst;
		burst = 0;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 39) == 0) burst = ~burst;	// gap-free stretches
			kind = $urandom_range(0, 9);
			la1 = 31'($urandom_range(0, 1800000000) - 900000000);
			lo1 = 32'($urandom_range(0, 32'd3600000000) - 1800000000);
			la2 = 31'($urandom_range(0, 1800000000) - 900000000);
			lo2 = 32'($urandom_range(0, 32'd3600000000) - 1800000000);
			case (kind)
				0: begin	// raw bits, out-of-range included
					la1 = 31'($urandom()); lo1 = $urandom();
					la2 = 31'($urandom()); lo2 = $urandom();
				end
				1: begin	// close neighbours, tiny a
					la2 = 31'(la1 + $signed($urandom_range(0, 2000)) - 1000);
					lo2 = 32'(lo1 + $signed($urandom_range(0, 2000)) - 1000);
				end
				2: begin	// near antipodal, a close to one
					la2 = 31'(-la1 + $signed($urandom_range(0, 200)) - 100);
					lo2 = 32'(lo1 + ((lo1 < 0) ? 1800000000 : -1800000000));
				end
				3: begin	// same point
					la2 = la1; lo2 = lo1;
				end
				default: ;
			endcase
			send_pair(la1, lo1, la2, lo2, 0, '0, draw_gap(burst));
		end
	endtask

	// ------------------------------------------------------------ directed rows
	typedef struct {
		logic signed [30:0] la1;
		logic signed [31:0] lo1;
		logic signed [30:0] la2;
		logic signed [31:0] lo2;
		bit typed;
		logic [DistW-1:0] want;
	} pair_row_t;

	localparam logic signed [30:0] LatMin = -31'sd1073741824;
	localparam logic signed [30:0] LatMax = 31'sd1073741823;
	localparam logic signed [31:0] LonMin = -32'sd2147483648;
	localparam logic signed [31:0] LonMax = 32'sd2147483647;

	pair_row_t pair_table[] = '{
		'{0, 0, 0, 0, 1, 0},	// origin to itself
		'{900000000, 1800000000, 900000000, 1800000000, 1, 0},
		'{LatMax, LonMax, LatMax, LonMax, 1, 0},
		'{LatMin, LonMin, LatMin, LonMin, 1, 0},
		'{0, 0, 0, 1, 0, 0},	// smallest step
		'{0, 0, 1, 0, 0, 0},
		'{900000000, 0, -900000000, 0, 0, 0},	// pole to pole
		'{0, -1800000000, 0, 1800000000, 0, 0},
		'{0, 0, 0, 1800000000, 0, 0},	// antipodal on equator
		'{0, 0, 0, -1800000000, 0, 0},
		'{450000000, 900000000, -450000000, -900000000, 0, 0},
		'{-900000000, -1800000000, 900000000, 1800000000, 0, 0},
		'{LatMin, LonMin, LatMax, LonMax, 0, 0},	// field extremes
		'{LatMax, LonMin, LatMin, LonMax, 0, 0},
		'{LatMax, 0, LatMin, 0, 0, 0},	// latitude beyond the pole
		'{0, LonMin, 0, LonMax, 0, 0},
		'{1000000000, 0, 1000000000, 1000000000, 0, 0},
		'{515000000, -1200000, 407000000, -740000000, 0, 0},
		'{-338000000, 1512000000, 357000000, 1397000000, 0, 0},
		'{899999999, 1, 899999999, 1799999999, 0, 0}
	};

	// -------------------------------------------------------------------- main
	initial begin
		radius_model = RadiusReset;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (pair_table[i])
			send_pair(pair_table[i].la1, pair_table[i].lo1, pair_table[i].la2,
				pair_table[i].lo2, pair_table[i].typed, pair_table[i].want,
				$urandom_range(0, 6));

		random_pairs(500);
		write_radius(24'd1);	// smallest nonzero radius
		random_pairs(300);
		write_radius(24'hFFFFFF);	// largest radius
		random_pairs(400);
		write_radius(24'd0);	// zero radius gives zero
		send_pair(0, 0, 0, 1800000000, 1, 0, 0);
		random_pairs(50);
		write_radius(24'($urandom_range(1, 24'hFFFFFF)));
		random_pairs(300);
		write_radius(RadiusReset);
		random_pairs(280);

		start <= 1'b0;
		wait (dist_expected.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
